// File: src/rdm_pkg.sv
`timescale 1ns / 1ps

package rdm_pkg;

   localparam int unsigned ADDR_BITS = 32;
   localparam int unsigned DATA_BITS = 32;
   localparam int unsigned OP_BITS = 2;
   localparam int unsigned LEN_BITS = 17;
   localparam int unsigned BYTE_BITS = 8;

   localparam logic [OP_BITS-1:0] OP_READ  = 2'd0;
   localparam logic [OP_BITS-1:0] OP_WRITE = 2'd1;
   localparam logic [OP_BITS-1:0] OP_COPY  = 2'd2;

   localparam int unsigned MAIN_BYTES = 65536;
   localparam int unsigned AUDIO_BYTES = 65536;
   localparam logic [ADDR_BITS-1:0] AUDIO_BASE = 32'h0400_0000;

   localparam int unsigned CACHE_ENTRIES = 256;
   localparam int unsigned INDEX_BITS = $clog2(CACHE_ENTRIES);
   localparam int unsigned INDEX_SHIFT = 6;

   localparam int unsigned LANES = DATA_BITS / BYTE_BITS;
   localparam int unsigned LANE_BITS = $clog2(LANES);
   localparam int unsigned TOTAL_BYTES = MAIN_BYTES + AUDIO_BYTES;
   localparam int unsigned UNI_BITS = $clog2(TOTAL_BYTES + LANES);
   localparam int unsigned ROWS = (TOTAL_BYTES + LANES - 1) / LANES;
   localparam int unsigned ROW_BITS = $clog2(ROWS);
   localparam int unsigned MAIN_BITS = $clog2(MAIN_BYTES);
   localparam int unsigned CNT_BITS = (MAIN_BITS + 1 > LEN_BITS) ? MAIN_BITS + 1 : LEN_BITS;

   typedef logic [LANES-1:0][BYTE_BITS-1:0] lane_data_type;

   typedef struct packed {
      logic                              rd_en;
      logic [LANES-1:0][ROW_BITS-1:0]    rd_row;
      logic [LANES-1:0]                  wr_en;
      logic [LANES-1:0][ROW_BITS-1:0]    wr_row;
      logic [LANES-1:0][BYTE_BITS-1:0]   wr_data;
   } store_req_type;

   typedef struct packed {
      logic                  rd;
      logic                  wr;
      logic                  inv;
      logic [INDEX_BITS-1:0] index;
      logic [ADDR_BITS-1:0]  tag;
      logic [DATA_BITS-1:0]  word;
   } cache_req_type;

   typedef struct packed {
      logic                 valid;
      logic [ADDR_BITS-1:0] tag;
      logic [DATA_BITS-1:0] word;
   } cache_rsp_type;

endpackage

// File: src/rdm_store.sv
`timescale 1ns / 1ps

module rdm_store (
   input  logic                  clock,
   input  rdm_pkg::store_req_type req,
   output rdm_pkg::lane_data_type rd_data
);
   import rdm_pkg::*;

   for (genvar j = 0; j < LANES; j++) begin : g_lane
      logic [BYTE_BITS-1:0] mem [ROWS];
      logic [BYTE_BITS-1:0] rd_ff;

      always_ff @(posedge clock) begin
         if (req.wr_en[j]) begin
            mem[req.wr_row[j]] <= req.wr_data[j];
         end
         if (req.rd_en) begin
            rd_ff <= mem[req.rd_row[j]];
         end
      end

      assign rd_data[j] = rd_ff;
   end

endmodule

// File: src/rdm_cache.sv
`timescale 1ns / 1ps

module rdm_cache (
   input  logic                  clock,
   input  logic                  reset,
   input  rdm_pkg::cache_req_type req,
   output rdm_pkg::cache_rsp_type rsp
);
   import rdm_pkg::*;

   logic [ADDR_BITS-1:0] tag_mem [CACHE_ENTRIES];
   logic [DATA_BITS-1:0] word_mem [CACHE_ENTRIES];
   logic [CACHE_ENTRIES-1:0] valid_ff;
   logic                 rd_valid_ff;
   logic [ADDR_BITS-1:0] rd_tag_ff;
   logic [DATA_BITS-1:0] rd_word_ff;

   always_ff @(posedge clock) begin
      if (req.wr) begin
         tag_mem[req.index] <= req.tag;
         word_mem[req.index] <= req.word;
      end
      if (req.rd) begin
         rd_tag_ff <= tag_mem[req.index];
         rd_word_ff <= word_mem[req.index];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (req.wr) begin
            valid_ff[req.index] <= 1'b1;
         end else if (req.inv) begin
            valid_ff[req.index] <= 1'b0;
         end
         if (req.rd) begin
            rd_valid_ff <= valid_ff[req.index];
         end
      end
   end

   assign rsp.valid = rd_valid_ff;
   assign rsp.tag = rd_tag_ff;
   assign rsp.word = rd_word_ff;

endmodule

// File: src/region_decoded_memory_with_read_cache.sv
// A read passes through the decode, memory read and data steps; the data step fills
// the cache on a miss, registers the result and holds while the response is stalled.
// A write passes through the decode and write steps. No new item is taken until the
// block is idle again. A copy of n bytes moves one byte per cycle through the byte-lane
// memories after set-up. After reset the stores are cleared one row of four bytes per
// cycle, 32768 rows, while req_stall stays high; the cache valid bits clear at once.
`timescale 1ns / 1ps

module region_decoded_memory_with_read_cache (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [rdm_pkg::OP_BITS-1:0]      req_operation,
   input  logic [rdm_pkg::ADDR_BITS-1:0]    req_address,
   input  logic [rdm_pkg::DATA_BITS-1:0]    req_write_data,
   input  logic [rdm_pkg::ADDR_BITS-1:0]    req_copy_source,
   input  logic [rdm_pkg::LEN_BITS-1:0]     req_copy_length,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [rdm_pkg::DATA_BITS-1:0]    rsp_read_data,
   output logic                             rsp_cache_hit
);
   import rdm_pkg::*;

   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_DEC   = 4'd2;
   localparam logic [3:0] ST_LOOK  = 4'd3;
   localparam logic [3:0] ST_DATA  = 4'd4;
   localparam logic [3:0] ST_WR    = 4'd5;
   localparam logic [3:0] ST_CSET  = 4'd6;
   localparam logic [3:0] ST_CPTR  = 4'd7;
   localparam logic [3:0] ST_CRUN  = 4'd8;

   logic [3:0]           state_ff;
   logic [3:0]           state_in;
   logic [OP_BITS-1:0]   op_ff;
   logic [ADDR_BITS-1:0] addr_ff;
   logic [DATA_BITS-1:0] wdata_ff;
   logic [ADDR_BITS-1:0] src_ff;
   logic [LEN_BITS-1:0]  len_ff;
   logic [UNI_BITS-1:0]  uni_ff;
   logic [UNI_BITS-1:0]  uni_in;
   logic [LANES-1:0]     mask_ff;
   logic [LANES-1:0]     mask_in;
   logic [ROW_BITS-1:0]  clr_row_ff;
   logic [CNT_BITS-1:0]  cnt_ff;
   logic [CNT_BITS-1:0]  cnt_in;
   logic [MAIN_BITS-1:0] rd_ptr_ff;
   logic [MAIN_BITS-1:0] wr_ptr_ff;
   logic [LANE_BITS-1:0] lane_ff;
   logic                 fwd_ff;
   logic                 pend_ff;
   logic                 rsp_valid_ff;
   logic [DATA_BITS-1:0] rsp_data_ff;
   logic                 rsp_hit_ff;

   logic                 accept;
   logic                 out_free;
   logic                 in_main;
   logic                 in_audio;
   logic [ADDR_BITS-1:0] aud_off;
   logic [ADDR_BITS-1:0] room;
   logic [CNT_BITS-1:0]  room_d;
   logic [CNT_BITS-1:0]  room_s;
   logic                 copy_ok;
   logic [LANES-1:0][LANE_BITS-1:0] lane_pos;
   logic [LANES-1:0][ROW_BITS-1:0]  lane_row;
   logic [DATA_BITS-1:0] fetched;
   logic                 hit;
   lane_data_type        rd_data;
   store_req_type        sreq;
   cache_req_type        creq;
   cache_rsp_type        crsp;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      in_main = addr_ff < ADDR_BITS'(MAIN_BYTES);
      aud_off = addr_ff - AUDIO_BASE;
      in_audio = (addr_ff >= AUDIO_BASE) && (aud_off < ADDR_BITS'(AUDIO_BYTES));
      room = in_main ? ADDR_BITS'(MAIN_BYTES) - addr_ff : ADDR_BITS'(AUDIO_BYTES) - aud_off;
      uni_in = in_main ? addr_ff[UNI_BITS-1:0]
                       : UNI_BITS'(MAIN_BYTES) + aud_off[UNI_BITS-1:0];
      for (int k = 0; k < LANES; k++) begin
         mask_in[k] = (in_main || in_audio) && (room > ADDR_BITS'(k));
      end
   end

   always_comb begin
      for (int j = 0; j < LANES; j++) begin
         lane_pos[j] = LANE_BITS'(j) - uni_ff[LANE_BITS-1:0];
         lane_row[j] = ROW_BITS'((uni_ff + UNI_BITS'(lane_pos[j])) >> LANE_BITS);
      end
      for (int k = 0; k < LANES; k++) begin
         fetched[k*BYTE_BITS +: BYTE_BITS] =
            mask_ff[k] ? rd_data[LANE_BITS'(uni_ff[LANE_BITS-1:0] + LANE_BITS'(k))] : '0;
      end
   end

   always_comb begin
      room_d = CNT_BITS'(MAIN_BYTES) - CNT_BITS'(addr_ff[MAIN_BITS-1:0]);
      room_s = CNT_BITS'(MAIN_BYTES) - CNT_BITS'(src_ff[MAIN_BITS-1:0]);
      copy_ok = (addr_ff < ADDR_BITS'(MAIN_BYTES)) && (src_ff < ADDR_BITS'(MAIN_BYTES));
      cnt_in = CNT_BITS'(len_ff);
      if (cnt_in > room_d) begin
         cnt_in = room_d;
      end
      if (cnt_in > room_s) begin
         cnt_in = room_s;
      end
      if (!copy_ok) begin
         cnt_in = '0;
      end
   end

   assign hit = crsp.valid && (crsp.tag == addr_ff);

   always_comb begin
      sreq = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            sreq.wr_en = '1;
            for (int j = 0; j < LANES; j++) begin
               sreq.wr_row[j] = clr_row_ff;
            end
         end
         ST_LOOK: begin
            sreq.rd_en = 1'b1;
            sreq.rd_row = lane_row;
         end
         ST_WR: begin
            sreq.wr_row = lane_row;
            for (int j = 0; j < LANES; j++) begin
               sreq.wr_en[j] = mask_ff[lane_pos[j]];
               sreq.wr_data[j] = wdata_ff[lane_pos[j]*BYTE_BITS +: BYTE_BITS];
            end
         end
         ST_CRUN: begin
            sreq.rd_en = (cnt_ff != '0);
            sreq.wr_en[wr_ptr_ff[LANE_BITS-1:0]] = pend_ff;
            for (int j = 0; j < LANES; j++) begin
               sreq.rd_row[j] = ROW_BITS'(rd_ptr_ff >> LANE_BITS);
               sreq.wr_row[j] = ROW_BITS'(wr_ptr_ff >> LANE_BITS);
               sreq.wr_data[j] = rd_data[lane_ff];
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      creq.rd = (state_ff == ST_LOOK);
      creq.wr = (state_ff == ST_DATA) && out_free && !hit;
      creq.inv = (state_ff == ST_WR);
      creq.index = addr_ff[INDEX_SHIFT +: INDEX_BITS];
      creq.tag = addr_ff;
      creq.word = fetched;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_row_ff == ROW_BITS'(ROWS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (req_operation)
                  OP_READ, OP_WRITE: state_in = ST_DEC;
                  OP_COPY: state_in = ST_CSET;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_DEC: state_in = (op_ff == OP_READ) ? ST_LOOK : ST_WR;
         ST_LOOK: state_in = ST_DATA;
         ST_DATA: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_WR: state_in = ST_IDLE;
         ST_CSET: state_in = ST_CPTR;
         ST_CPTR: state_in = ST_CRUN;
         ST_CRUN: begin
            if (cnt_ff == '0 && !pend_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_row_ff <= '0;
         cnt_ff <= '0;
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_row_ff <= clr_row_ff + 1'b1;
         end
         if (state_ff == ST_CSET) begin
            cnt_ff <= cnt_in;
         end
         if (state_ff == ST_CPTR) begin
            pend_ff <= 1'b0;
         end else if (state_ff == ST_CRUN) begin
            pend_ff <= (cnt_ff != '0);
            if (cnt_ff != '0) begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
         if (state_ff == ST_DATA && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= req_operation;
         addr_ff <= req_address;
         wdata_ff <= req_write_data;
         src_ff <= req_copy_source;
         len_ff <= req_copy_length;
      end
      if (state_ff == ST_DEC) begin
         uni_ff <= uni_in;
         mask_ff <= mask_in;
      end
      if (state_ff == ST_CSET) begin
         fwd_ff <= addr_ff[MAIN_BITS-1:0] <= src_ff[MAIN_BITS-1:0];
      end
      if (state_ff == ST_CPTR) begin
         if (fwd_ff) begin
            rd_ptr_ff <= src_ff[MAIN_BITS-1:0];
            wr_ptr_ff <= addr_ff[MAIN_BITS-1:0];
         end else begin
            rd_ptr_ff <= src_ff[MAIN_BITS-1:0] + MAIN_BITS'(cnt_ff - 1'b1);
            wr_ptr_ff <= addr_ff[MAIN_BITS-1:0] + MAIN_BITS'(cnt_ff - 1'b1);
         end
      end else if (state_ff == ST_CRUN) begin
         if (cnt_ff != '0) begin
            lane_ff <= rd_ptr_ff[LANE_BITS-1:0];
            rd_ptr_ff <= fwd_ff ? rd_ptr_ff + 1'b1 : rd_ptr_ff - 1'b1;
         end
         if (pend_ff) begin
            wr_ptr_ff <= fwd_ff ? wr_ptr_ff + 1'b1 : wr_ptr_ff - 1'b1;
         end
      end
      if (state_ff == ST_DATA && out_free) begin
         rsp_data_ff <= hit ? crsp.word : fetched;
         rsp_hit_ff <= hit;
      end
   end

   rdm_store u_store (
      .clock   (clock),
      .req     (sreq),
      .rd_data (rd_data)
   );

   rdm_cache u_cache (
      .clock (clock),
      .reset (reset),
      .req   (creq),
      .rsp   (crsp)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_cache_hit = rsp_hit_ff;

   a_rsp_from_data: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DATA)
      else $error("result appeared outside the data step");

   a_copy_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CRUN && cnt_ff == '0 && !pend_ff) |=> state_ff == ST_IDLE)
      else $error("copy did not finish after its last byte");

   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (!rsp_valid_ff && !creq.wr && !creq.rd))
      else $error("activity during the clearing pass");

endmodule
